>>> src/base32_text_encoder_defines.svh
// ---------------------------------------------------------------------------
// base32 text encoder assertion macros
// concurrent assertion shorthands, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef BASE32_TEXT_ENCODER_DEFINES_SVH
`define BASE32_TEXT_ENCODER_DEFINES_SVH

// same-cycle implication
`define B32ENC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b32enc assertion failed");

// next-cycle implication
`define B32ENC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b32enc assertion failed");

`endif

>>> src/b32enc_pkg.sv
// ---------------------------------------------------------------------------
// b32enc_pkg
// shared types, constants and alphabet table of the base32 text encoder
// ---------------------------------------------------------------------------
package b32enc_pkg;

  localparam int unsigned SymW    = 5;
  localparam int unsigned CharW   = 7;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned MaxSyms = 3;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] CHAR_DASH = 7'h2D;

  // register indexes
  localparam logic REG_GROUP_LENGTH = 1'b0;

  // alphabet without 0, 1, I and O
  localparam logic [CharW-1:0] ALPHABET [32] = '{
    7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b32enc_in_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } b32enc_out_t;

  // one classified byte: its symbols in order
  typedef struct packed {
    logic [MaxSyms-1:0][SymW-1:0] syms;
    logic [1:0]                   n_sym;
    logic                         msg_last;
  } b32enc_item_t;

endpackage

>>> src/b32enc_front.sv
// ---------------------------------------------------------------------------
// b32enc_front
// splits each byte plus leftover bits into five-bit symbols
// ---------------------------------------------------------------------------
module b32enc_front
  import b32enc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  b32enc_in_t   in_i,
  output b32enc_item_t item_o
);

  logic [3:0]  lb_q, lb_d;
  logic [2:0]  lc_q, lc_d;
  logic [11:0] acc;
  logic [3:0]  bits;
  logic [3:0]  rem;
  logic [11:0] sh0, sh1, shf;
  logic [4:0]  mask;

  always_comb begin
    acc  = {lb_q, in_i.data_byte};
    bits = {1'b0, lc_q} + 4'd8;
    sh0  = acc >> (bits - 4'd5);
    sh1  = '0;
    item_o = '0;
    item_o.syms[0]  = sh0[SymW-1:0];
    item_o.msg_last = in_i.last_byte;
    if (bits >= 4'd10) begin
      sh1 = acc >> (bits - 4'd10);
      item_o.syms[1] = sh1[SymW-1:0];
      item_o.n_sym   = 2'd2;
      rem            = bits - 4'd10;
    end else begin
      item_o.n_sym = 2'd1;
      rem          = bits - 4'd5;
    end
    // flush of leftover bits, zero padded on the right
    shf = acc << (4'd5 - rem);
    if (in_i.last_byte && (rem != 4'd0)) begin
      if (item_o.n_sym == 2'd1) begin
        item_o.syms[1] = shf[SymW-1:0];
      end else begin
        item_o.syms[2] = shf[SymW-1:0];
      end
      item_o.n_sym = item_o.n_sym + 2'd1;
    end
    mask = (5'd1 << rem) - 5'd1;
    if (in_i.last_byte) begin
      lb_d = '0;
      lc_d = '0;
    end else begin
      lb_d = acc[3:0] & mask[3:0];
      lc_d = rem[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= '0;
      lc_q <= '0;
    end else if (accept_i) begin
      lb_q <= lb_d;
      lc_q <= lc_d;
    end
  end

endmodule

>>> src/b32enc_queue.sv
// ---------------------------------------------------------------------------
// b32enc_queue
// short queue of classified bytes between front and back
// ---------------------------------------------------------------------------
module b32enc_queue
  import b32enc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  b32enc_item_t wr_item_i,
  input  logic         rd_en_i,
  output b32enc_item_t rd_item_o,
  output logic         valid_o,
  output logic         full_o
);

  b32enc_item_t     mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign rd_item_o = mem_q[rd_ptr_q];
  assign valid_o   = (cnt_q != '0);
  assign full_o    = (cnt_q == QCntW'(QDepth));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> src/b32enc_back.sv
// ---------------------------------------------------------------------------
// b32enc_back
// emits one character or dash a cycle into the output register while an item waits and the register is free or popped
// ---------------------------------------------------------------------------
module b32enc_back
  import b32enc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GroupW-1:0] group_length_i,
  input  b32enc_item_t      item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output b32enc_out_t       out_o
);

  logic [GroupW-1:0] cig_q, cig_d;
  logic              any_q, any_d;
  logic [1:0]        idx_q, idx_d;
  logic              vld_q, vld_d;
  b32enc_out_t       out_q, out_d;
  logic              advance, need_dash, final_sym;
  logic [SymW-1:0]   sym;

  always_comb begin
    advance   = item_valid_i && (!vld_q || pop_i);
    need_dash = (group_length_i != '0) && any_q && (cig_q >= group_length_i);
    final_sym = (idx_q == (item_i.n_sym - 2'd1));
    sym       = item_i.syms[idx_q];
    cig_d      = cig_q;
    any_d      = any_q;
    idx_d      = idx_q;
    out_d      = out_q;
    item_pop_o = 1'b0;
    vld_d      = pop_i ? 1'b0 : vld_q;
    if (advance) begin
      vld_d = 1'b1;
      if (need_dash) begin
        out_d = '{char_code: CHAR_DASH, last_char: 1'b0};
        cig_d = '0;
      end else begin
        out_d = '{char_code: ALPHABET[sym], last_char: final_sym && item_i.msg_last};
        cig_d = (group_length_i != '0) ? cig_q + 1'b1 : '0;
        any_d = 1'b1;
        if (final_sym) begin
          item_pop_o = 1'b1;
          idx_d      = '0;
          if (item_i.msg_last) begin
            cig_d = '0;
            any_d = 1'b0;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cig_q <= '0;
      any_q <= 1'b0;
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cig_q <= cig_d;
      any_q <= any_d;
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = vld_q;
  assign out_o       = out_q;

endmodule

>>> src/base32_text_encoder.sv
// path: a byte's symbols are written into the queue, then each character into the
// output register, which drives the result ports
// throughput: one character or dash per cycle from the back unless pop stalls it, one
// to three characters per byte plus dashes; the front is combinational and the two-entry
// queue lets it keep taking beats while the back is busy with a dash or a stalled pop
// reset: rst_ni asynchronous active low, clears leftover bits, group counter, queue
// pointers, output valid and group_length; no clearing pass
// ---------------------------------------------------------------------------
// base32_text_encoder
// byte stream to base32 text with custom alphabet and optional dash grouping
// ---------------------------------------------------------------------------
module base32_text_encoder
  import b32enc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte side
  input  logic        push,
  output logic        full,
  input  b32enc_in_t  in_data_i,
  // character side
  output logic        empty,
  input  logic        pop,
  output b32enc_out_t out_data_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GroupW-1:0] group_length_q;
  logic              in_accept;
  b32enc_item_t      front_item, head_item;
  logic              head_valid, head_pop;
  logic              out_valid;

  // register file: one register, decoded on paddr[2] alone, at byte addresses zero to three
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_length_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_GROUP_LENGTH)) begin
      group_length_q <= pwdata[GroupW-1:0];
    end
  end

  // read back, addresses beyond the register read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GROUP_LENGTH) begin
      prdata = {{(32 - GroupW){1'b0}}, group_length_q};
    end
  end

  // a beat is taken whenever the queue has room
  assign in_accept = push && !full;

  // front: classify byte into its symbols
  b32enc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .in_i     (in_data_i),
    .item_o   (front_item)
  );

  // decoupling queue
  b32enc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept),
    .wr_item_i (front_item),
    .rd_en_i   (head_pop),
    .rd_item_o (head_item),
    .valid_o   (head_valid),
    .full_o    (full)
  );

  // back: dash insertion, alphabet lookup, output register
  b32enc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_length_i (group_length_q),
    .item_i         (head_item),
    .item_valid_i   (head_valid),
    .item_pop_o     (head_pop),
    .pop_i          (pop),
    .out_valid_o    (out_valid),
    .out_o          (out_data_o)
  );

  assign empty = !out_valid;

endmodule

>>> src/b32enc_checker.sv
// ---------------------------------------------------------------------------
// b32enc_checker
// port-level checks on the base32 text encoder
// ---------------------------------------------------------------------------
`include "base32_text_encoder_defines.svh"

module b32enc_checker
  import b32enc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input b32enc_in_t  in_data_i,
  input logic        empty,
  input logic        pop,
  input b32enc_out_t out_data_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a dash never closes a message
  `B32ENC_ASSERT_NOW(a_dash_not_last, !empty && (out_data_o.char_code == CHAR_DASH),
                     !out_data_o.last_char)

  // no 0, 1, I or O character leaves the block
  `B32ENC_ASSERT_NOW(a_legal_char, !empty,
                     (out_data_o.char_code != 7'h30) && (out_data_o.char_code != 7'h31) &&
                     (out_data_o.char_code != 7'h49) && (out_data_o.char_code != 7'h4F))

  // a stalled beat holds
  `B32ENC_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_data_o))

  // register read back is only as wide as the register
  `B32ENC_ASSERT_NOW(a_prdata_width, psel, (prdata[31:GroupW] == '0) && pready)

endmodule

bind base32_text_encoder b32enc_checker u_b32enc_checker (.*);
